// ----- rtl/core/afr_pkg.sv -----
// shared types and constants for the addressed frame receiver
package afr_pkg;

  // receiver phase, unused codes behave as waiting for start
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_ADDRESS = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_RECEIVE = 3'd3,
    PH_SKIP    = 3'd4
  } phase_t;

  // result event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_INFO    = 2'd1,
    EV_PAYLOAD = 2'd2,
    EV_FOREIGN = 2'd3
  } evt_code_t;

  // bus characters
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_QUERY = 8'd63;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;

  // device id after reset
  localparam logic [7:0] DEVICE_ID_RESET = 8'd1;

  // broadcast address
  localparam logic [7:0] ADDR_BROADCAST = 8'd0;

  // receiver state carried from byte to byte
  typedef struct packed {
    phase_t          phase;
    logic [2:0][7:0] recent;
    logic            for_other;
    logic [7:0]      frame_len;
    logic [7:0]      byte_idx;
  } afr_state_t;

  // one result item
  typedef struct packed {
    evt_code_t  event_res;
    logic [7:0] payload_byte;
    logic       last_of_frame;
  } afr_result_t;

endpackage

// ----- rtl/core/afr_step.sv -----
// per-byte next state and result logic of the frame receiver
module afr_step #(
  parameter int unsigned MAX_FRAME_LENGTH = 128
) (
  input  afr_pkg::afr_state_t  state_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           device_id_i,
  output afr_pkg::afr_state_t  state_o,
  output afr_pkg::afr_result_t result_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LENGTH);

  logic       frame_start;
  logic       info_seen;
  logic       len_bad;
  logic [7:0] idx_inc;
  logic [7:0] len_dec;

  // shared decodes
  always_comb begin
    frame_start = (state_i.recent[2] == afr_pkg::CH_COLON) &&
                  (rx_byte_i == afr_pkg::CH_COLON);
    info_seen   = (state_i.recent[1] == afr_pkg::CH_QUERY) &&
                  (state_i.recent[2] == afr_pkg::CH_CR) &&
                  (rx_byte_i == afr_pkg::CH_LF);
    len_bad     = (rx_byte_i <= 8'd1) || (rx_byte_i > MaxLen);
    idx_inc     = state_i.byte_idx + 8'd1;
    len_dec     = state_i.frame_len - 8'd1;
  end

  // next phase
  always_comb begin
    state_o.phase = afr_pkg::PH_START;
    unique case (state_i.phase)
      afr_pkg::PH_ADDRESS: begin
        state_o.phase = afr_pkg::PH_LENGTH;
      end
      afr_pkg::PH_LENGTH: begin
        if (len_bad) begin
          state_o.phase = afr_pkg::PH_START;
        end else if (state_i.for_other) begin
          state_o.phase = afr_pkg::PH_SKIP;
        end else begin
          state_o.phase = afr_pkg::PH_RECEIVE;
        end
      end
      afr_pkg::PH_RECEIVE: begin
        state_o.phase = (idx_inc >= state_i.frame_len) ? afr_pkg::PH_START
                                                       : afr_pkg::PH_RECEIVE;
      end
      afr_pkg::PH_SKIP: begin
        state_o.phase = (len_dec == 8'd0) ? afr_pkg::PH_START : afr_pkg::PH_SKIP;
      end
      default: begin
        state_o.phase = frame_start ? afr_pkg::PH_ADDRESS : afr_pkg::PH_START;
      end
    endcase
  end

  // state data and result
  always_comb begin
    state_o.recent    = state_i.recent;
    state_o.for_other = state_i.for_other;
    state_o.frame_len = state_i.frame_len;
    state_o.byte_idx  = state_i.byte_idx;
    result_o.event_res     = afr_pkg::EV_NONE;
    result_o.payload_byte  = 8'd0;
    result_o.last_of_frame = 1'b0;
    unique case (state_i.phase)
      afr_pkg::PH_ADDRESS: begin
        state_o.for_other = !((rx_byte_i == device_id_i) ||
                              (rx_byte_i == afr_pkg::ADDR_BROADCAST));
        state_o.frame_len = 8'd0;
      end
      afr_pkg::PH_LENGTH: begin
        if (len_bad) begin
          state_o.frame_len = 8'd0;
        end else begin
          state_o.frame_len = rx_byte_i;
          state_o.byte_idx  = 8'd0;
        end
      end
      afr_pkg::PH_RECEIVE: begin
        state_o.byte_idx      = idx_inc;
        result_o.event_res    = afr_pkg::EV_PAYLOAD;
        result_o.payload_byte = rx_byte_i;
        if (idx_inc >= state_i.frame_len) begin
          result_o.last_of_frame = 1'b1;
          state_o.byte_idx       = 8'd0;
          state_o.frame_len      = 8'd0;
        end
      end
      afr_pkg::PH_SKIP: begin
        state_o.frame_len = len_dec;
        if (len_dec == 8'd0) begin
          result_o.event_res = afr_pkg::EV_FOREIGN;
          state_o.byte_idx   = 8'd0;
        end
      end
      default: begin
        // waiting for start: shift history, look for colons or info request
        if (frame_start) begin
          state_o.recent = '0;
        end else begin
          state_o.recent[0] = state_i.recent[1];
          state_o.recent[1] = state_i.recent[2];
          state_o.recent[2] = rx_byte_i;
          if (info_seen) begin
            result_o.event_res = afr_pkg::EV_INFO;
          end
        end
      end
    endcase
  end

endmodule

// ----- rtl/core/afr_out_buf.sv -----
// two-entry output register with skid stage for result requests
module afr_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  afr_pkg::afr_result_t push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output afr_pkg::afr_result_t out_data_o
);

  logic                 main_valid_r;
  logic                 skid_valid_r;
  afr_pkg::afr_result_t main_data_r;
  afr_pkg::afr_result_t skid_data_r;
  logic                 main_free;

  assign main_free = !main_valid_r || !out_stall_i;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      main_valid_r <= skid_valid_r || push_i;
      skid_valid_r <= 1'b0;
    end else if (push_i) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data_r <= skid_valid_r ? skid_data_r : push_data_i;
    end else if (push_i) begin
      skid_data_r <= push_data_i;
    end
  end

  assign full_o      = skid_valid_r;
  assign out_valid_o = main_valid_r;
  assign out_data_o  = main_data_r;

endmodule

// ----- rtl/core/addressed_frame_receiver.sv -----
// top level of the addressed frame receiver
//
//   port group   direction  handshake            payload
//   in_          into       in_valid / in_stall  in_rx_byte
//   out_         out of     out_valid/out_stall  out_event_res, out_payload_byte,
//                                                out_last_of_frame
//   cfg_         into       cfg_wr_en            cfg_wr_data (device id)
//
// one byte is accepted per cycle while in_stall is low; its result is computed
// combinationally and registered in the output register, or in the skid stage.
// a skid stage behind the output register keeps input open for one more
// request while out_stall is high; in_stall rises only when both are held.
// reset is synchronous, active low, and leaves the block waiting for a frame
// start with device id 1.
module addressed_frame_receiver #(
  parameter int unsigned MAX_FRAME_LENGTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [7:0] out_payload_byte,
  output logic       out_last_of_frame,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic                 in_accept;
  logic                 buf_full;
  logic [7:0]           device_id_r;
  afr_pkg::afr_state_t  state_r;
  afr_pkg::afr_state_t  state_nxt;
  afr_pkg::afr_result_t step_result;
  afr_pkg::afr_result_t out_result;

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= afr_pkg::DEVICE_ID_RESET;
    end else if (cfg_wr_en) begin
      device_id_r <= cfg_wr_data;
    end
  end

  // receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= afr_pkg::PH_START;
      state_r.recent    <= '0;
      state_r.for_other <= 1'b0;
      state_r.frame_len <= 8'd0;
      state_r.byte_idx  <= 8'd0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // per-byte logic
  afr_step #(
    .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
  ) u_step (
    .state_i     (state_r),
    .rx_byte_i   (in_rx_byte),
    .device_id_i (device_id_r),
    .state_o     (state_nxt),
    .result_o    (step_result)
  );

  // result register and skid
  afr_out_buf u_out_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_accept),
    .push_data_i (step_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_result)
  );

  assign out_event_res     = out_result.event_res;
  assign out_payload_byte  = out_result.payload_byte;
  assign out_last_of_frame = out_result.last_of_frame;

`ifndef NO_ASSERTIONS
  // a held skid entry means the output register is occupied
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid stage full while output register empty");

  // last flag only on payload results
  a_last_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_frame) |-> (out_event_res == afr_pkg::EV_PAYLOAD))
    else $error("last flag on a non-payload result");

  // receive phase is only entered for own or broadcast frames
  a_receive_own: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == afr_pkg::PH_RECEIVE) |-> !state_r.for_other)
    else $error("receiving a frame addressed to another device");

  // skip phase always has bytes left
  a_skip_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == afr_pkg::PH_SKIP) |-> (state_r.frame_len != 8'd0))
    else $error("skip phase with zero remaining length");
`endif

endmodule
